### hw/rtl/mpq_pkg.sv
// shared constants and codes for the max priority queue
package mpq_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam int KEY_W        = 32;
	localparam int ACT_W        = 2;
	localparam int STAT_W       = 3;

	localparam logic [ACT_W-1:0] ACT_INSERT  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_EXTRACT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DELETE  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_CHANGE  = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STAT_W-1:0] ST_RANGE     = 3'd4;

endpackage

### hw/rtl/mpq_heap_ram.sv
// key store: one write port, one read port with registered read data
module mpq_heap_ram #(
	parameter int DEPTH = mpq_pkg::CAPACITY_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [AW-1:0]                    waddr,
	input  logic signed [mpq_pkg::KEY_W-1:0] wdata,
	input  logic [AW-1:0]                    raddr,
	output logic signed [mpq_pkg::KEY_W-1:0] rdata
);
	import mpq_pkg::*;

	logic signed [KEY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/mpq_seq.sv
// heap sequencer: search, sift up and sift down over the key store
module mpq_seq #(
	parameter int CAPACITY = mpq_pkg::CAPACITY_DEF,
	localparam int CW = $clog2(CAPACITY + 1),
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	output logic                             done,
	input  logic [mpq_pkg::ACT_W-1:0]        action,
	input  logic signed [mpq_pkg::KEY_W-1:0] key_value,
	input  logic [CW-1:0]                    position,
	output logic [mpq_pkg::STAT_W-1:0]       status,
	output logic signed [mpq_pkg::KEY_W-1:0] removed_key,
	output logic signed [mpq_pkg::KEY_W-1:0] root_key,
	output logic [CW-1:0]                    entry_count,
	output logic                             mem_we,
	output logic [AW-1:0]                    mem_waddr,
	output logic signed [mpq_pkg::KEY_W-1:0] mem_wdata,
	output logic [AW-1:0]                    mem_raddr,
	input  logic signed [mpq_pkg::KEY_W-1:0] mem_rdata
);
	import mpq_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_LAST     = 4'd1;
	localparam logic [3:0] S_SCAN     = 4'd2;
	localparam logic [3:0] S_DEL_LAST = 4'd3;
	localparam logic [3:0] S_UP_RD    = 4'd4;
	localparam logic [3:0] S_UP_CMP   = 4'd5;
	localparam logic [3:0] S_DN_L     = 4'd6;
	localparam logic [3:0] S_DN_R     = 4'd7;
	localparam logic [3:0] S_DN_C     = 4'd8;
	localparam logic [3:0] S_DONE     = 4'd9;

	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	logic [3:0]              state_q;
	logic [CW-1:0]           n_q;
	logic [CW-1:0]           i_q;
	logic [CW-1:0]           scan_q;
	logic [CW-1:0]           chk_pos_q;
	logic                    chk_v_q;
	logic signed [KEY_W-1:0] v_q;
	logic signed [KEY_W-1:0] key_q;
	logic signed [KEY_W-1:0] big_v_q;
	logic                    big_l_q;
	logic                    down_q;
	logic                    moved_q;
	logic [STAT_W-1:0]       status_q;
	logic signed [KEY_W-1:0] removed_q;
	logic signed [KEY_W-1:0] top_q;

	logic [CW:0]             left_pos;
	logic [CW:0]             right_pos;
	logic                    left_in;
	logic                    right_in;
	logic [CW-1:0]           parent_pos;
	logic                    up_go;
	logic                    dn_rgt;
	logic                    hit;
	logic                    not_found;
	logic                    stop_here;
	logic [CW-1:0]           wpos;
	logic [CW-1:0]           rpos;
	logic [CW-1:0]           wpos_m1;
	logic [CW-1:0]           rpos_m1;
	logic                    accept;

	assign accept     = start && (state_q == S_IDLE);
	assign left_pos   = {i_q, 1'b0};
	assign right_pos  = {i_q, 1'b1};
	assign left_in    = left_pos <= {1'b0, n_q};
	assign right_in   = right_pos <= {1'b0, n_q};
	assign parent_pos = i_q >> 1;
	assign up_go      = mem_rdata < v_q;
	assign dn_rgt     = right_in && (mem_rdata > big_v_q);
	assign hit        = chk_v_q && (mem_rdata == key_q);
	assign not_found  = chk_v_q && !hit && (chk_pos_q == n_q);
	// resift stops after the up pass if it moved anything
	assign stop_here  = moved_q || !down_q;

	always_comb begin
		mem_we    = 1'b0;
		wpos      = i_q;
		mem_wdata = v_q;
		rpos      = n_q;
		unique case (state_q)
			S_IDLE: begin
				rpos = n_q;
			end
			S_SCAN: begin
				rpos = hit ? n_q : scan_q;
			end
			S_UP_RD: begin
				rpos = parent_pos;
				if (i_q == ONE_C && stop_here) begin
					mem_we = 1'b1;
				end
			end
			S_UP_CMP: begin
				if (up_go) begin
					mem_we    = 1'b1;
					mem_wdata = mem_rdata;
				end else if (stop_here) begin
					mem_we = 1'b1;
				end
			end
			S_DN_L: begin
				rpos = left_pos[CW-1:0];
				if (!left_in) begin
					mem_we = 1'b1;
				end
			end
			S_DN_R: begin
				rpos = right_pos[CW-1:0];
			end
			S_DN_C: begin
				mem_we = 1'b1;
				if (dn_rgt) begin
					mem_wdata = mem_rdata;
				end else if (big_l_q) begin
					mem_wdata = big_v_q;
				end
			end
			S_LAST, S_DEL_LAST, S_DONE: begin
				rpos = n_q;
			end
			default: begin
				rpos = n_q;
			end
		endcase
	end

	// positions count from one, addresses from zero
	assign wpos_m1   = wpos - ONE_C;
	assign rpos_m1   = rpos - ONE_C;
	assign mem_waddr = wpos_m1[AW-1:0];
	assign mem_raddr = rpos_m1[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we && wpos == ONE_C) begin
			top_q <= mem_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
			chk_v_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q     <= key_value;
						status_q  <= ST_OK;
						removed_q <= '0;
						moved_q   <= 1'b0;
						case (action)
							ACT_INSERT: begin
								if (n_q >= CAP_C) begin
									status_q <= ST_FULL;
									state_q  <= S_DONE;
								end else begin
									n_q     <= n_q + ONE_C;
									i_q     <= n_q + ONE_C;
									v_q     <= key_value;
									down_q  <= 1'b0;
									state_q <= S_UP_RD;
								end
							end
							ACT_EXTRACT: begin
								if (n_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_DONE;
								end else begin
									removed_q <= top_q;
									state_q   <= S_LAST;
								end
							end
							ACT_DELETE: begin
								if (n_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_DONE;
								end else begin
									scan_q  <= ONE_C;
									chk_v_q <= 1'b0;
									state_q <= S_SCAN;
								end
							end
							default: begin
								if (position == '0 || position > n_q) begin
									status_q <= ST_RANGE;
									state_q  <= S_DONE;
								end else begin
									i_q     <= position;
									v_q     <= key_value;
									down_q  <= 1'b1;
									state_q <= S_UP_RD;
								end
							end
						endcase
					end
				end
				S_LAST: begin
					v_q     <= mem_rdata;
					n_q     <= n_q - ONE_C;
					i_q     <= ONE_C;
					state_q <= S_DN_L;
				end
				S_SCAN: begin
					if (hit) begin
						removed_q <= mem_rdata;
						i_q       <= chk_pos_q;
						chk_v_q   <= 1'b0;
						state_q   <= S_DEL_LAST;
					end else if (not_found) begin
						status_q <= ST_NOT_FOUND;
						chk_v_q  <= 1'b0;
						state_q  <= S_DONE;
					end else begin
						chk_pos_q <= scan_q;
						chk_v_q   <= 1'b1;
						scan_q    <= scan_q + ONE_C;
					end
				end
				S_DEL_LAST: begin
					v_q    <= mem_rdata;
					n_q    <= n_q - ONE_C;
					down_q <= 1'b1;
					// the removed word was the last one: nothing to repair
					state_q <= (i_q == n_q) ? S_DONE : S_UP_RD;
				end
				S_UP_RD: begin
					if (i_q == ONE_C) begin
						state_q <= stop_here ? S_DONE : S_DN_L;
					end else begin
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (up_go) begin
						i_q     <= parent_pos;
						moved_q <= 1'b1;
						state_q <= S_UP_RD;
					end else begin
						state_q <= stop_here ? S_DONE : S_DN_L;
					end
				end
				S_DN_L: begin
					state_q <= left_in ? S_DN_R : S_DONE;
				end
				S_DN_R: begin
					big_l_q <= mem_rdata > v_q;
					big_v_q <= (mem_rdata > v_q) ? mem_rdata : v_q;
					state_q <= S_DN_C;
				end
				S_DN_C: begin
					if (dn_rgt) begin
						i_q     <= right_pos[CW-1:0];
						state_q <= S_DN_L;
					end else if (big_l_q) begin
						i_q     <= left_pos[CW-1:0];
						state_q <= S_DN_L;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = state_q != S_IDLE;
	assign done        = state_q == S_DONE;
	assign status      = status_q;
	assign removed_key = removed_q;
	assign root_key    = top_q;
	assign entry_count = n_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CAP_C)
		else $error("entry count above capacity");

	// an extract that empties the heap still writes the root back
	a_sift_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UP_RD || state_q == S_UP_CMP || state_q == S_DN_L ||
		 state_q == S_DN_R || state_q == S_DN_C) |->
		(i_q != '0 && (i_q <= n_q || n_q == '0)))
		else $error("sift position outside the held entries");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_q == ST_FULL) |-> (n_q == CAP_C))
		else $error("full reported below capacity");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_q == ST_EMPTY) |-> (n_q == '0))
		else $error("empty reported with entries held");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && action == ACT_INSERT && n_q < CAP_C) |=> (n_q == $past(n_q) + ONE_C))
		else $error("insert did not add an entry");

endmodule

### hw/rtl/max_priority_queue.sv
// max priority queue: binary max heap of signed keys in a single-port-read key store
// insert climbs level by level, ending early when it lands at the root; extract descends
// level by level, ending early at a leaf; errors go straight to the result strobe
// change key re-sifts: a climb as for insert, or else the extract walk
// delete first scans the entries in order up to the match (all of them when absent)
// throughput: one word at a time, busy high until the result strobe; one read per cycle
// reset clears the entry count and the sequencer; the store itself is not cleared.
module max_priority_queue #(
	parameter int CAPACITY = mpq_pkg::CAPACITY_DEF,
	localparam int CW = $clog2(CAPACITY + 1),
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	output logic                             done,
	input  logic [mpq_pkg::ACT_W-1:0]        action,
	input  logic signed [mpq_pkg::KEY_W-1:0] key_value,
	input  logic [CW-1:0]                    position,
	output logic [mpq_pkg::STAT_W-1:0]       status,
	output logic signed [mpq_pkg::KEY_W-1:0] removed_key,
	output logic signed [mpq_pkg::KEY_W-1:0] top_key,
	output logic [CW-1:0]                    entry_count
);
	import mpq_pkg::*;

	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic signed [KEY_W-1:0] mem_wdata;
	logic [AW-1:0]           mem_raddr;
	logic signed [KEY_W-1:0] mem_rdata;
	logic signed [KEY_W-1:0] root_key;

	mpq_seq #(
		.CAPACITY(CAPACITY)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.done       (done),
		.action     (action),
		.key_value  (key_value),
		.position   (position),
		.status     (status),
		.removed_key(removed_key),
		.root_key   (root_key),
		.entry_count(entry_count),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	mpq_heap_ram #(
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// root word is stale once the heap runs empty
	assign top_key = (entry_count != '0) ? root_key : '0;

endmodule

### dv/tb_max_priority_queue.sv
// self-checking testbench for the max priority queue: directed plan, random traffic, heap predictor
module tb_max_priority_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import mpq_pkg::*;

	localparam int CAP   = CAPACITY_DEF;
	localparam int CW    = $clog2(CAP + 1);
	localparam int LIMIT = 8_000_000;
	localparam int TAIL  = 1200;
	localparam logic signed [KEY_W-1:0] KMAX = 32'sh7FFF_FFFF;
	localparam logic signed [KEY_W-1:0] KMIN = 32'sh8000_0000;

	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic signed [KEY_W-1:0] removed;
		logic signed [KEY_W-1:0] top;
		logic [CW-1:0]           count;
	} reply_t;

	typedef struct packed {
		logic [ACT_W-1:0]        act;
		logic signed [KEY_W-1:0] key;
		logic [CW-1:0]           pos;
		bit                      fixed;
		reply_t                  reply;
	} plan_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    done;
	logic [ACT_W-1:0]        action;
	logic signed [KEY_W-1:0] key_value;
	logic [CW-1:0]           position;
	logic [STAT_W-1:0]       status;
	logic signed [KEY_W-1:0] removed_key;
	logic signed [KEY_W-1:0] top_key;
	logic [CW-1:0]           entry_count;

	// predictor copy of the heap, positions 1..heap_size
	logic signed [KEY_W-1:0] heap_keys [1:CAP];
	int unsigned             heap_size = 0;
	reply_t                  replies [$];
	int unsigned             fail_count = 0;
	int unsigned             words_seen = 0;
	int unsigned             cycle_count = 0;
	int unsigned             burst_left = 0;

	// opening checks: empty cases, extremes, range and not-found codes, then re-sifts
	plan_row_t plan [0:22] = '{
		'{ACT_EXTRACT, 32'sd0,     11'd0,    1'b1, '{ST_EMPTY,     32'sd0, 32'sd0, 11'd0}},
		'{ACT_DELETE,  32'sd0,     11'd0,    1'b1, '{ST_EMPTY,     32'sd0, 32'sd0, 11'd0}},
		'{ACT_CHANGE,  32'sd9,     11'd1,    1'b1, '{ST_RANGE,     32'sd0, 32'sd0, 11'd0}},
		'{ACT_CHANGE,  32'sd9,     11'd0,    1'b1, '{ST_RANGE,     32'sd0, 32'sd0, 11'd0}},
		'{ACT_INSERT,  KMAX,       11'd0,    1'b1, '{ST_OK,        32'sd0, KMAX,   11'd1}},
		'{ACT_INSERT,  KMIN,       11'd0,    1'b1, '{ST_OK,        32'sd0, KMAX,   11'd2}},
		'{ACT_INSERT,  32'sd5,     11'd0,    1'b0, '0},
		'{ACT_INSERT,  32'sd5,     11'd0,    1'b0, '0},
		'{ACT_INSERT,  -32'sd1,    11'd0,    1'b0, '0},
		'{ACT_INSERT,  32'sd7,     11'd0,    1'b0, '0},
		'{ACT_CHANGE,  32'sd3,     11'd0,    1'b1, '{ST_RANGE,     32'sd0, KMAX,   11'd6}},
		'{ACT_CHANGE,  32'sd3,     11'd7,    1'b1, '{ST_RANGE,     32'sd0, KMAX,   11'd6}},
		'{ACT_CHANGE,  32'sd3,     11'd2047, 1'b1, '{ST_RANGE,     32'sd0, KMAX,   11'd6}},
		'{ACT_DELETE,  32'sd12345, 11'd0,    1'b1, '{ST_NOT_FOUND, 32'sd0, KMAX,   11'd6}},
		'{ACT_DELETE,  32'sd5,     11'd0,    1'b0, '0},
		'{ACT_CHANGE,  KMIN,       11'd1,    1'b0, '0},
		'{ACT_CHANGE,  32'sd100,   11'd5,    1'b0, '0},
		'{ACT_DELETE,  KMIN,       11'd0,    1'b0, '0},
		'{ACT_EXTRACT, 32'sd0,     11'd0,    1'b0, '0},
		'{ACT_EXTRACT, 32'sd0,     11'd0,    1'b0, '0},
		'{ACT_EXTRACT, 32'sd0,     11'd0,    1'b0, '0},
		'{ACT_EXTRACT, 32'sd0,     11'd0,    1'b0, '0},
		'{ACT_EXTRACT, 32'sd0,     11'd0,    1'b1, '{ST_EMPTY,     32'sd0, 32'sd0, 11'd0}}
	};

	max_priority_queue DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.done        (done),
		.action      (action),
		.key_value   (key_value),
		.position    (position),
		.status      (status),
		.removed_key (removed_key),
		.top_key     (top_key),
		.entry_count (entry_count)
	);

	always begin
		#5ns clk = 1'b1;
		#5ns clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic void swap_keys(input int unsigned a, input int unsigned b);
		logic signed [KEY_W-1:0] t;
		t = heap_keys[a];
		heap_keys[a] = heap_keys[b];
		heap_keys[b] = t;
	endfunction

	function automatic void bubble_up(input int unsigned i);
		while (i > 1 && heap_keys[i / 2] < heap_keys[i]) begin
			swap_keys(i, i / 2);
			i = i / 2;
		end
	endfunction

	// left child wins ties, strict compares only
	function automatic void sink_down(input int unsigned i);
		int unsigned l, r, big;
		while (1) begin
			l = 2 * i;
			r = 2 * i + 1;
			big = i;
			if (l <= heap_size && heap_keys[l] > heap_keys[big])
				big = l;
			if (r <= heap_size && heap_keys[r] > heap_keys[big])
				big = r;
			if (big == i)
				return;
			swap_keys(i, big);
			i = big;
		end
	endfunction

	function automatic reply_t heap_step(input logic [ACT_W-1:0] act,
			input logic signed [KEY_W-1:0] key, input logic [CW-1:0] pos);
		reply_t r;
		int unsigned i;
		r = '0;
		r.status = ST_OK;
		case (act)
			ACT_INSERT: begin
				if (heap_size >= CAP) begin
					r.status = ST_FULL;
				end else begin
					heap_size++;
					heap_keys[heap_size] = key;
					bubble_up(heap_size);
				end
			end
			ACT_EXTRACT: begin
				if (heap_size == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.removed = heap_keys[1];
					heap_keys[1] = heap_keys[heap_size];
					heap_size--;
					sink_down(1);
				end
			end
			ACT_DELETE: begin
				if (heap_size == 0) begin
					r.status = ST_EMPTY;
				end else begin
					i = 1;
					while (i <= heap_size && heap_keys[i] != key)
						i++;
					if (i > heap_size) begin
						r.status = ST_NOT_FOUND;
					end else begin
						r.removed = heap_keys[i];
						heap_keys[i] = heap_keys[heap_size];
						heap_size--;
						// re-sift from the vacated spot, down pass starts there too
						if (i <= heap_size) begin
							bubble_up(i);
							sink_down(i);
						end
					end
				end
			end
			default: begin
				if (pos == 0 || pos > heap_size) begin
					r.status = ST_RANGE;
				end else begin
					heap_keys[pos] = key;
					bubble_up(pos);
					sink_down(pos);
				end
			end
		endcase
		r.top = (heap_size != 0) ? heap_keys[1] : '0;
		r.count = CW'(heap_size);
		return r;
	endfunction

	function automatic logic signed [KEY_W-1:0] pick_key();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		// narrow range gives duplicates and ties
		if (roll < 35)
			return $signed($urandom_range(0, 16)) - 8;
		if (roll < 45) begin
			case ($urandom_range(0, 4))
				0: return KMAX;
				1: return KMIN;
				2: return -1;
				3: return 0;
				default: return 1;
			endcase
		end
		return $urandom;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on word %0d, %s: got %h, want %h", words_seen, what, got, want);
		fail_count++;
	endtask

	// bursts of back-to-back words with random gaps between them
	task automatic issue_word(input logic [ACT_W-1:0] act, input logic signed [KEY_W-1:0] key,
			input logic [CW-1:0] pos, input bit fixed, input reply_t fixed_reply);
		int unsigned gap;
		reply_t r;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
			if (gap != 0) begin
				start <= 1'b0;
				action <= ACT_W'($urandom);
				key_value <= $urandom;
				position <= CW'($urandom);
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		start <= 1'b1;
		action <= act;
		key_value <= key;
		position <= pos;
		do @(posedge clk); while (busy);
		r = heap_step(act, key, pos);
		replies.push_back(fixed ? fixed_reply : r);
		burst_left--;
	endtask

	task automatic random_word(input int unsigned w_ins, input int unsigned w_ext,
			input int unsigned w_del);
		int unsigned roll;
		logic [ACT_W-1:0] act;
		logic signed [KEY_W-1:0] key;
		logic [CW-1:0] pos;
		roll = $urandom_range(0, 99);
		if (roll < w_ins)
			act = ACT_INSERT;
		else if (roll < w_ins + w_ext)
			act = ACT_EXTRACT;
		else if (roll < w_ins + w_ext + w_del)
			act = ACT_DELETE;
		else
			act = ACT_CHANGE;
		key = pick_key();
		pos = CW'($urandom_range(0, (1 << CW) - 1));
		if (act == ACT_DELETE && heap_size != 0 && $urandom_range(0, 9) < 7)
			key = heap_keys[$urandom_range(1, heap_size)];
		if (act == ACT_CHANGE && heap_size != 0 && $urandom_range(0, 9) < 8)
			pos = CW'($urandom_range(1, heap_size));
		issue_word(act, key, pos, 1'b0, '0);
	endtask

	task automatic wait_drained();
		while (replies.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && done) begin
			if (replies.size() == 0) begin
				report_mismatch("unexpected word", 32'(status), 32'(entry_count));
			end else begin
				want = replies.pop_front();
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
				if (removed_key !== want.removed)
					report_mismatch("removed_key", removed_key, want.removed);
				if (top_key !== want.top)
					report_mismatch("top_key", top_key, want.top);
				if (entry_count !== want.count)
					report_mismatch("entry_count", 32'(entry_count), 32'(want.count));
			end
			words_seen++;
		end
	end

	initial begin
		wait (cycle_count >= LIMIT);
		$display("timeout after %0d cycles, %0d words outstanding", cycle_count, replies.size());
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		action <= ACT_INSERT;
		key_value <= '0;
		position <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k])
			issue_word(plan[k].act, plan[k].key, plan[k].pos, plan[k].fixed, plan[k].reply);

		// small heap, drifting through empty now and then
		repeat (60)
			random_word(35, 25, 20);

		start <= 1'b0;
		wait_drained();

		// fill to capacity with a few deletes and key changes along the way
		while (heap_size < CAP)
			random_word(90, 0, 5);

		// at capacity: full inserts, boundary positions, a full-length search
		repeat (3)
			issue_word(ACT_INSERT, pick_key(), CW'($urandom), 1'b0, '0);
		issue_word(ACT_CHANGE, pick_key(), CW'(CAP), 1'b0, '0);
		issue_word(ACT_CHANGE, pick_key(), CW'(CAP + 1), 1'b0, '0);
		issue_word(ACT_CHANGE, pick_key(), CW'((1 << CW) - 1), 1'b0, '0);
		issue_word(ACT_DELETE, $urandom, '0, 1'b0, '0);

		repeat (110)
			random_word(35, 35, 10);

		start <= 1'b0;
		wait_drained();
		repeat (TAIL) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
